FILE: rtl/core/dsa_pkg.sv
// Shared types, constants and modular add/subtract helpers for the DSA block.
// Used by the divider, the modular multiplier, the arithmetic engine and the top level.
`timescale 1ns / 1ps
`default_nettype none
package dsa_pkg;

  localparam int NUM_BITS  = 32;
  localparam int CNT_W     = $clog2(NUM_BITS + 1);
  localparam int CFG_IDX_W = 3;
  localparam int IN_W      = 2 * NUM_BITS;
  localparam int OUT_W     = 6 * NUM_BITS;

  typedef logic [NUM_BITS-1:0] word_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRIME = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SEED  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_KEY   = CFG_IDX_W'(3);

  localparam word_t RST_PRIME = NUM_BITS'(11);
  localparam word_t RST_ORDER = NUM_BITS'(5);
  localparam word_t RST_SEED  = NUM_BITS'(2);
  localparam word_t RST_KEY   = NUM_BITS'(3);

  // engine operations
  typedef enum logic [2:0] {
    OP_QUO = 3'd0,
    OP_REM = 3'd1,
    OP_MUL = 3'd2,
    OP_ADD = 3'd3,
    OP_POW = 3'd4,
    OP_INV = 3'd5
  } op_t;

  typedef struct packed {
    logic  go;
    word_t num;
    word_t den;
  } div_req_t;

  typedef struct packed {
    logic  done;
    logic  idle;
    word_t quo;
    word_t rem;
  } div_rsp_t;

  typedef struct packed {
    logic  go;
    word_t a;
    word_t b;
    word_t m;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    logic  idle;
    word_t prod;
  } mul_rsp_t;

  typedef struct packed {
    logic  go;
    op_t   op;
    word_t a;
    word_t b;
    word_t m;
  } eng_req_t;

  typedef struct packed {
    logic  done;
    logic  idle;
    word_t res;
  } eng_rsp_t;

  // x + y mod m, x and y already below m
  function automatic word_t add_mod(word_t x, word_t y, word_t m);
    logic [NUM_BITS:0] sum;
    sum = {1'b0, x} + {1'b0, y};
    if (sum >= {1'b0, m}) sum = sum - {1'b0, m};
    return sum[NUM_BITS-1:0];
  endfunction

  // x - y mod m, x and y already below m
  function automatic word_t sub_mod(word_t x, word_t y, word_t m);
    logic [NUM_BITS:0] dif;
    dif = {1'b0, x} - {1'b0, y};
    if (x < y) dif = dif + {1'b0, m};
    return dif[NUM_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/dsa_sign_and_verify.sv
// Top level: configuration registers, stream handshake and the signing/verification sequence.
// Depends on dsa_pkg, dsa_div, dsa_mulmod and dsa_engine.
//
//   channel   direction  beat contents (low bits first)
//   s_axis    in         message_hash[31:0], nonce[63:32]
//   m_axis    out        sig_r, sig_s, inv_s, hash_weight, r_weight, check_value
//   cfg       in         cfg_index selects p, q, h or x; cfg_data is the value
//
// One beat is worked at a time through eighteen engine steps. Each power costs up to two
// multiplies per exponent bit and each inverse one division and one multiply per Euclid
// step.
// Reset (synchronous) restores p=11, q=5, h=2, x=3 and empties the output register.
// A new input beat is taken while a finished result still waits on m_axis.
`timescale 1ns / 1ps
`default_nettype none
module dsa_sign_and_verify import dsa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_W-1:0]      s_axis_tdata,   // message_hash, nonce
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_W-1:0]     m_axis_tdata,   // sig_r, sig_s, inv_s, hash_weight,
                                               // r_weight, check_value
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  word_t                cfg_data
);

  typedef enum logic [3:0] {
    T_IDLE  = 4'b0001,
    T_ISSUE = 4'b0010,
    T_WAIT  = 4'b0100,
    T_FIN   = 4'b1000
  } top_state_t;

  typedef enum logic [17:0] {
    ST_GEXP = 18'h00001,
    ST_G    = 18'h00002,
    ST_T    = 18'h00004,
    ST_R    = 18'h00008,
    ST_KINV = 18'h00010,
    ST_HQ   = 18'h00020,
    ST_XQ   = 18'h00040,
    ST_XR   = 18'h00080,
    ST_SUM  = 18'h00100,
    ST_S    = 18'h00200,
    ST_W    = 18'h00400,
    ST_U1   = 18'h00800,
    ST_U2   = 18'h01000,
    ST_Y    = 18'h02000,
    ST_A1   = 18'h04000,
    ST_A2   = 18'h08000,
    ST_V    = 18'h10000,
    ST_VQ   = 18'h20000
  } step_t;

  top_state_t state;
  step_t      step;
  word_t      prime, order, seed, key;
  word_t      hash, k;
  word_t      gexp, g, t, r, kinv, hq, xq, xr, sum, s, w, u1, u2, y, a1, a2, v, vq;
  logic       out_valid;
  logic [OUT_W-1:0] out_data;
  eng_req_t   eng_req;
  eng_rsp_t   eng_rsp;
  div_req_t   div_req;
  div_rsp_t   div_rsp;
  mul_req_t   mul_req;
  mul_rsp_t   mul_rsp;

  dsa_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));
  dsa_mulmod u_mul (.clk(clk), .rst(rst), .req(mul_req), .rsp(mul_rsp));
  dsa_engine u_eng (
    .clk(clk), .rst(rst), .req(eng_req), .rsp(eng_rsp),
    .div_req(div_req), .div_rsp(div_rsp), .mul_req(mul_req), .mul_rsp(mul_rsp)
  );

  // configuration writes; unknown indexes are dropped
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      prime <= RST_PRIME;
      order <= RST_ORDER;
      seed  <= RST_SEED;
      key   <= RST_KEY;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PRIME: prime <= cfg_data;
        CFG_ORDER: order <= cfg_data;
        CFG_SEED:  seed  <= cfg_data;
        CFG_KEY:   key   <= cfg_data;
        default: ;
      endcase
    end
  end

  // operation and operands of the current step
  always_comb begin
    eng_req    = '0;
    eng_req.go = (state == T_ISSUE);
    unique case (step)
      ST_GEXP: eng_req = '{eng_req.go, OP_QUO, prime - word_t'(1), order, prime};
      ST_G:    eng_req = '{eng_req.go, OP_POW, seed, gexp, prime};
      ST_T:    eng_req = '{eng_req.go, OP_POW, g, k, prime};
      ST_R:    eng_req = '{eng_req.go, OP_REM, t, order, order};
      ST_KINV: eng_req = '{eng_req.go, OP_INV, k, k, order};
      ST_HQ:   eng_req = '{eng_req.go, OP_REM, hash, order, order};
      ST_XQ:   eng_req = '{eng_req.go, OP_REM, key, order, order};
      ST_XR:   eng_req = '{eng_req.go, OP_MUL, xq, r, order};
      ST_SUM:  eng_req = '{eng_req.go, OP_ADD, hq, xr, order};
      ST_S:    eng_req = '{eng_req.go, OP_MUL, kinv, sum, order};
      ST_W:    eng_req = '{eng_req.go, OP_INV, s, s, order};
      ST_U1:   eng_req = '{eng_req.go, OP_MUL, hq, w, order};
      ST_U2:   eng_req = '{eng_req.go, OP_MUL, r, w, order};
      ST_Y:    eng_req = '{eng_req.go, OP_POW, g, key, prime};
      ST_A1:   eng_req = '{eng_req.go, OP_POW, g, u1, prime};
      ST_A2:   eng_req = '{eng_req.go, OP_POW, y, u2, prime};
      ST_V:    eng_req = '{eng_req.go, OP_MUL, a1, a2, prime};
      ST_VQ:   eng_req = '{eng_req.go, OP_REM, v, order, order};
      default: ;
    endcase
  end

  // sequence control, step results and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      step      <= ST_GEXP;
      out_valid <= 1'b0;
    end else begin
      // output register: loaded from the finish step, emptied on a taken beat
      if ((state == T_FIN) && (!out_valid || m_axis_tready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (s_axis_tvalid) begin
            hash  <= s_axis_tdata[NUM_BITS-1:0];
            k     <= s_axis_tdata[IN_W-1:NUM_BITS];
            step  <= ST_GEXP;
            state <= T_ISSUE;
          end
        end
        T_ISSUE: begin
          state <= T_WAIT;
        end
        T_WAIT: begin
          if (eng_rsp.done) begin
            state <= (step == ST_VQ) ? T_FIN : T_ISSUE;
            unique case (step)
              ST_GEXP: begin gexp <= eng_rsp.res; step <= ST_G;    end
              ST_G:    begin g    <= eng_rsp.res; step <= ST_T;    end
              ST_T:    begin t    <= eng_rsp.res; step <= ST_R;    end
              ST_R:    begin r    <= eng_rsp.res; step <= ST_KINV; end
              ST_KINV: begin kinv <= eng_rsp.res; step <= ST_HQ;   end
              ST_HQ:   begin hq   <= eng_rsp.res; step <= ST_XQ;   end
              ST_XQ:   begin xq   <= eng_rsp.res; step <= ST_XR;   end
              ST_XR:   begin xr   <= eng_rsp.res; step <= ST_SUM;  end
              ST_SUM:  begin sum  <= eng_rsp.res; step <= ST_S;    end
              ST_S:    begin s    <= eng_rsp.res; step <= ST_W;    end
              ST_W:    begin w    <= eng_rsp.res; step <= ST_U1;   end
              ST_U1:   begin u1   <= eng_rsp.res; step <= ST_U2;   end
              ST_U2:   begin u2   <= eng_rsp.res; step <= ST_Y;    end
              ST_Y:    begin y    <= eng_rsp.res; step <= ST_A1;   end
              ST_A1:   begin a1   <= eng_rsp.res; step <= ST_A2;   end
              ST_A2:   begin a2   <= eng_rsp.res; step <= ST_V;    end
              ST_V:    begin v    <= eng_rsp.res; step <= ST_VQ;   end
              ST_VQ:   begin vq   <= eng_rsp.res; step <= ST_GEXP; end
              default: step <= ST_GEXP;
            endcase
          end
        end
        T_FIN: begin
          // hand over once the output register is free or being emptied
          if (!out_valid || m_axis_tready) begin
            out_data  <= {vq, u2, u1, w, s, r};
            state     <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == T_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  a_issue_to_idle_engine: assert property (@(posedge clk) disable iff (rst)
    eng_req.go |-> eng_rsp.idle)
    else $error("engine given work while busy");
  a_done_only_waiting: assert property (@(posedge clk) disable iff (rst)
    eng_rsp.done |-> state == T_WAIT)
    else $error("engine finished outside a wait step");
  a_fin_loads_free_reg: assert property (@(posedge clk) disable iff (rst)
    (state == T_FIN) && !out_valid |=> out_valid && (state == T_IDLE))
    else $error("finished result not loaded into a free output register");

endmodule
`default_nettype wire

FILE: rtl/core/dsa_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on dsa_pkg. A zero divisor gives zero quotient and remainder.
`timescale 1ns / 1ps
`default_nettype none
module dsa_div import dsa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  word_t             num_sh;
  word_t             quo;
  word_t             rem;
  word_t             den;
  logic              den_zero;
  logic [NUM_BITS:0] rem_sh;
  logic [NUM_BITS:0] rem_new;
  logic              fits;

  // trial subtract of the divisor from the shifted partial remainder
  always_comb begin
    rem_sh  = {rem, num_sh[NUM_BITS-1]};
    fits    = (rem_sh >= {1'b0, den});
    rem_new = fits ? (rem_sh - {1'b0, den}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        busy     <= 1'b1;
        cnt      <= CNT_W'(NUM_BITS);
        num_sh   <= req.num;
        den      <= req.den;
        den_zero <= (req.den == '0);
        rem      <= '0;
        quo      <= '0;
      end else if (busy) begin
        rem    <= rem_new[NUM_BITS-1:0];
        quo    <= {quo[NUM_BITS-2:0], fits};
        num_sh <= {num_sh[NUM_BITS-2:0], 1'b0};
        cnt    <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.idle = !busy;
  assign rsp.quo  = den_zero ? '0 : quo;
  assign rsp.rem  = den_zero ? '0 : rem;

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    rsp.done && !den_zero |-> rsp.rem < den)
    else $error("divider remainder not below divisor");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    req.go |-> !busy)
    else $error("divider started while busy");

endmodule
`default_nettype wire

FILE: rtl/core/dsa_mulmod.sv
// Bit-serial modular multiplier: a doubling step, then a conditional add step, for each bit of b.
// Depends on dsa_pkg. Operands must already be below the modulus.
`timescale 1ns / 1ps
`default_nettype none
module dsa_mulmod import dsa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic             busy;
  logic             done;
  logic             phase;
  logic [CNT_W-1:0] cnt;
  word_t            acc;
  word_t            a;
  word_t            m;
  word_t            b_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        cnt   <= CNT_W'(NUM_BITS);
        acc   <= '0;
        a     <= req.a;
        m     <= req.m;
        b_sh  <= req.b;
      end else if (busy) begin
        if (!phase) begin
          // doubling step
          acc   <= add_mod(acc, acc, m);
          phase <= 1'b1;
        end else begin
          // add a where the current bit of b is set
          if (b_sh[NUM_BITS-1]) acc <= add_mod(acc, a, m);
          b_sh  <= {b_sh[NUM_BITS-2:0], 1'b0};
          phase <= 1'b0;
          cnt   <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.idle = !busy;
  assign rsp.prod = acc;

  a_prod_reduced: assert property (@(posedge clk) disable iff (rst)
    rsp.done && (m != '0) |-> rsp.prod < m)
    else $error("modular product not reduced");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    req.go |-> !busy)
    else $error("multiplier started while busy");

endmodule
`default_nettype wire

FILE: rtl/core/dsa_engine.sv
// Arithmetic engine: quotient, remainder, modular add, multiply, power and inverse.
// Depends on dsa_pkg; drives one dsa_div and one dsa_mulmod.
`timescale 1ns / 1ps
`default_nettype none
module dsa_engine import dsa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  eng_req_t req,
  output eng_rsp_t rsp,
  output div_req_t div_req,
  input  div_rsp_t div_rsp,
  output mul_req_t mul_req,
  input  mul_rsp_t mul_rsp
);

  typedef enum logic [13:0] {
    E_IDLE   = 14'h0001,
    E_QR     = 14'h0002,
    E_MUL    = 14'h0004,
    E_P_ONE  = 14'h0008,
    E_P_BASE = 14'h0010,
    E_P_TEST = 14'h0020,
    E_P_MUL  = 14'h0040,
    E_P_SQR  = 14'h0080,
    E_I_RED  = 14'h0100,
    E_I_ONE  = 14'h0200,
    E_I_TEST = 14'h0400,
    E_I_DIV  = 14'h0800,
    E_I_MUL  = 14'h1000,
    E_DONE   = 14'h2000
  } eng_state_t;

  eng_state_t state;
  op_t        op;
  word_t      abuf;
  word_t      ex;
  word_t      m;
  word_t      res;
  word_t      bs;
  word_t      r0;
  word_t      r1;
  word_t      t0;
  word_t      t1;
  word_t      result;
  div_req_t   dreq;
  mul_req_t   mreq;
  word_t      qm;

  // Euclid quotient reduced mod m; it reaches m only on the first step with a remainder of one
  assign qm = (div_rsp.quo == m) ? '0 : div_rsp.quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= E_IDLE;
      dreq.go <= 1'b0;
      mreq.go <= 1'b0;
    end else begin
      dreq.go <= 1'b0;
      mreq.go <= 1'b0;
      unique case (state)
        E_IDLE: begin
          if (req.go) begin
            op   <= req.op;
            m    <= req.m;
            abuf <= req.a;
            ex   <= req.b;
            case (req.op)
              OP_QUO, OP_REM: begin
                dreq <= '{go: 1'b1, num: req.a, den: req.b};
                state <= E_QR;
              end
              OP_MUL: begin
                mreq <= '{go: 1'b1, a: req.a, b: req.b, m: req.m};
                state <= E_MUL;
              end
              OP_POW: begin
                dreq <= '{go: 1'b1, num: word_t'(1), den: req.m};
                state <= E_P_ONE;
              end
              OP_INV: begin
                r0   <= req.m;
                dreq <= '{go: 1'b1, num: req.a, den: req.m};
                state <= E_I_RED;
              end
              default: begin
                result <= add_mod(req.a, req.b, req.m);
                state  <= E_DONE;
              end
            endcase
          end
        end
        E_QR: begin
          if (div_rsp.done) begin
            result <= (op == OP_QUO) ? div_rsp.quo : div_rsp.rem;
            state  <= E_DONE;
          end
        end
        E_MUL: begin
          if (mul_rsp.done) begin
            result <= mul_rsp.prod;
            state  <= E_DONE;
          end
        end
        // power: result starts at 1 mod m, base reduced, then right-to-left square and multiply
        E_P_ONE: begin
          if (div_rsp.done) begin
            res  <= div_rsp.rem;
            dreq <= '{go: 1'b1, num: abuf, den: m};
            state <= E_P_BASE;
          end
        end
        E_P_BASE: begin
          if (div_rsp.done) begin
            bs    <= div_rsp.rem;
            state <= E_P_TEST;
          end
        end
        E_P_TEST: begin
          if (ex == '0) begin
            result <= res;
            state  <= E_DONE;
          end else if (ex[0]) begin
            mreq  <= '{go: 1'b1, a: res, b: bs, m: m};
            state <= E_P_MUL;
          end else begin
            mreq  <= '{go: 1'b1, a: bs, b: bs, m: m};
            state <= E_P_SQR;
          end
        end
        E_P_MUL: begin
          if (mul_rsp.done) begin
            res <= mul_rsp.prod;
            if (ex[NUM_BITS-1:1] == '0) begin
              // last exponent bit: the final squaring is not needed
              result <= mul_rsp.prod;
              state  <= E_DONE;
            end else begin
              mreq  <= '{go: 1'b1, a: bs, b: bs, m: m};
              state <= E_P_SQR;
            end
          end
        end
        E_P_SQR: begin
          if (mul_rsp.done) begin
            bs    <= mul_rsp.prod;
            ex    <= {1'b0, ex[NUM_BITS-1:1]};
            state <= E_P_TEST;
          end
        end
        // inverse: extended Euclid on (m, a mod m), tracking only the t coefficients
        E_I_RED: begin
          if (div_rsp.done) begin
            r1   <= div_rsp.rem;
            t0   <= '0;
            dreq <= '{go: 1'b1, num: word_t'(1), den: m};
            state <= E_I_ONE;
          end
        end
        E_I_ONE: begin
          if (div_rsp.done) begin
            t1    <= div_rsp.rem;
            state <= E_I_TEST;
          end
        end
        E_I_TEST: begin
          if (r1 == '0) begin
            result <= (r0 == word_t'(1)) ? t0 : '0;
            state  <= E_DONE;
          end else begin
            dreq  <= '{go: 1'b1, num: r0, den: r1};
            state <= E_I_DIV;
          end
        end
        E_I_DIV: begin
          if (div_rsp.done) begin
            mreq  <= '{go: 1'b1, a: qm, b: t1, m: m};
            r0    <= r1;
            r1    <= div_rsp.rem;
            state <= E_I_MUL;
          end
        end
        E_I_MUL: begin
          if (mul_rsp.done) begin
            t1    <= sub_mod(t0, mul_rsp.prod, m);
            t0    <= t1;
            state <= E_I_TEST;
          end
        end
        E_DONE: begin
          state <= E_IDLE;
        end
        default: begin
          state <= E_IDLE;
        end
      endcase
    end
  end

  assign div_req  = dreq;
  assign mul_req  = mreq;
  assign rsp.done = (state == E_DONE);
  assign rsp.idle = (state == E_IDLE);
  assign rsp.res  = result;

  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == E_QR) || (state == E_P_ONE) || (state == E_P_BASE)
                     || (state == E_I_RED) || (state == E_I_ONE) || (state == E_I_DIV))
    else $error("divider result arrived in an unexpected state");
  a_mul_done_expected: assert property (@(posedge clk) disable iff (rst)
    mul_rsp.done |-> (state == E_MUL) || (state == E_P_MUL) || (state == E_P_SQR)
                     || (state == E_I_MUL))
    else $error("multiplier result arrived in an unexpected state");

endmodule
`default_nettype wire
